### rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by dq_cell and double_ended_queue; no dependencies.
package dq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic             shift_right;  // push at front: take left neighbor
        logic             shift_left;   // pop at front: take right neighbor
        logic             load_back;    // push at back: cell at count loads
        logic [CNT_W-1:0] count;        // elements stored before this action
    } t_cell_ctl;

endpackage

### rtl/dq_cell.sv
// One storage cell of the queue row: holds the element at a fixed
// distance from the front. Depends on dq_pkg.
module dq_cell (
    input  logic                      i_clk,
    input  logic [dq_pkg::IDX_W-1:0]  i_index,
    input  dq_pkg::t_cell_ctl         i_ctl,
    input  logic [dq_pkg::VAL_W-1:0]  i_left,
    input  logic [dq_pkg::VAL_W-1:0]  i_right,
    input  logic [dq_pkg::VAL_W-1:0]  i_push,
    input  logic [dq_pkg::VAL_W-1:0]  i_tap,
    output logic [dq_pkg::VAL_W-1:0]  o_value,
    output logic [dq_pkg::VAL_W-1:0]  o_tap
);
    import dq_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic             is_back;
    logic             is_slot;

    // This cell holds the back element, or is the first free slot
    assign is_back = ((CNT_W'(i_index) + CNT_W'(1)) == i_ctl.count);
    assign is_slot = (CNT_W'(i_index) == i_ctl.count);

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.shift_right) begin
            n_value = i_left;
        end else if (i_ctl.shift_left) begin
            n_value = i_right;
        end else if (i_ctl.load_back && is_slot) begin
            n_value = i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // Pass the back element down the row toward the end of the chain
    assign o_tap   = i_tap | (is_back ? r_value : '0);

endmodule

### rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// Depends on dq_pkg and dq_cell.
//
// Double-ended queue of DEPTH (16) signed 32-bit values held in a row of
// cells, cell 0 always holding the front element. One action is taken per
// clock unless the result side stalls: push front shifts the whole row one
// cell back and loads cell 0, pop front shifts it one cell forward, push
// back loads the cell at the current count, and pop back picks the last
// occupied cell through a tap chain that runs along the row. Every action
// gives one result transfer from an output register, loaded when the
// action is accepted; the input side keeps taking actions while the result
// side takes them, so the sustained rate is one action per clock. A pop
// from an empty queue returns 0 with the empty error set; a push into a
// full queue is dropped with the full error set. Neither changes the stored
// elements.
module double_ended_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] popped_value, [32] empty_error,
                                        // [33] full_error, [38:34] element_count,
                                        // [39] now_empty
);
    import dq_pkg::*;

    // Control and result registers
    logic             r_out_valid;
    logic             n_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [VAL_W-1:0] r_popped;
    logic [VAL_W-1:0] n_popped;
    logic             r_empty_err;
    logic             n_empty_err;
    logic             r_full_err;
    logic             n_full_err;

    logic             accept;
    t_action          action;
    logic             is_full;
    logic             is_empty;
    t_cell_ctl        ctl;

    logic [VAL_W-1:0] cell_val [DEPTH];
    logic [VAL_W-1:0] tap      [DEPTH+1];

    // Take a new action whenever the result register is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = t_action'(s_axis_tuser);
    assign is_full       = (r_count == CNT_W'(DEPTH));
    assign is_empty      = (r_count == '0);

    // Decode the action into row commands; hold the row when idle or on error
    always_comb begin
        ctl.shift_right = 1'b0;
        ctl.shift_left  = 1'b0;
        ctl.load_back   = 1'b0;
        ctl.count       = r_count;
        n_count         = r_count;
        n_popped        = '0;
        n_empty_err     = 1'b0;
        n_full_err      = 1'b0;
        unique case (action)
            ACT_PUSH_FRONT: begin
                n_full_err      = is_full;
                ctl.shift_right = accept && !is_full;
                if (!is_full) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_PUSH_BACK: begin
                n_full_err    = is_full;
                ctl.load_back = accept && !is_full;
                if (!is_full) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_POP_FRONT: begin
                n_empty_err    = is_empty;
                ctl.shift_left = accept && !is_empty;
                if (!is_empty) begin
                    n_count  = r_count - CNT_W'(1);
                    n_popped = cell_val[0];
                end
            end
            ACT_POP_BACK: begin
                n_empty_err = is_empty;
                if (!is_empty) begin
                    n_count  = r_count - CNT_W'(1);
                    n_popped = tap[DEPTH];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Row of cells; the tap chain starts empty at the front
    assign tap[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = s_axis_tdata;
        end else begin : g_mid
            assign left_val = cell_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = cell_val[g+1];
        end

        dq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctl   (ctl),
            .i_left  (left_val),
            .i_right (right_val),
            .i_push  (s_axis_tdata),
            .i_tap   (tap[g]),
            .o_value (cell_val[g]),
            .o_tap   (tap[g+1])
        );
    end

    // Advance the result register on accept, drop valid once transferred
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped    <= n_popped;
            r_empty_err <= n_empty_err;
            r_full_err  <= n_full_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(r_count == '0), 5'(r_count), r_full_err, r_empty_err, r_popped};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not grow the queue");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_empty && (action == ACT_POP_FRONT || action == ACT_POP_BACK))
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not shrink the queue");

    a_one_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_empty_err && r_full_err))
        else $error("both error flags raised");

endmodule
